@@ sv/gaussian_kernel_regression_top_assert.svh @@
// Assertion macros for the kernel regression block.
`ifndef GAUSSIAN_KERNEL_REGRESSION_TOP_ASSERT_SVH
`define GAUSSIAN_KERNEL_REGRESSION_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GKR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GKR_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GKR_ASSERT(lbl, clk, rst, prop, msg)
`define GKR_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ sv/gkr_pkg.sv @@
package gkr_pkg;

   localparam int DEF_MAX_SAMPLES = 1024;
   localparam int DEF_MAX_DIMS    = 8;

   localparam int MODE_W   = 2;
   localparam int SIDX_W   = 10;
   localparam int DIDX_W   = 3;
   localparam int VAL_W    = 24;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int SCNT_W     = 11;
   localparam int DUSED_W    = 4;
   localparam int INVW_W     = 24;

   localparam logic [MODE_W-1:0] MODE_FEATURE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TARGET  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_EVAL    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_USED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH    = 2'd2;

   localparam logic [SCNT_W-1:0]  RST_SAMPLE_COUNT = 11'd0;
   localparam logic [DUSED_W-1:0] RST_DIMS_USED    = 4'd7;
   localparam logic [INVW_W-1:0]  RST_INV_WIDTH    = 24'd102400;

   localparam int SD_W   = 48;   // scaled distance, 16 fraction bits
   localparam int A_W    = 44;   // d2 >> 8
   localparam int HALF_W = 22;   // a is multiplied in two halves
   localparam int PH_W   = HALF_W + INVW_W;
   localparam int PSUM_W = A_W + INVW_W;
   localparam int PSAT_B = 56;
   localparam int MUL_W  = 26;
   localparam int PROD_W = 2 * MUL_W;
   localparam int EXP_W  = 17;

   localparam logic [SD_W-1:0] LOG_CUTOFF = 48'd256378;

   localparam logic [EXP_W-1:0] EXP_INT [4] = '{
      17'd65536, 17'd24109, 17'd8869, 17'd3263};
   localparam logic [EXP_W-1:0] EXP_SIXTEENTH [16] = '{
      17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042, 17'd42313,
      17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081, 17'd27319, 17'd25664};
   localparam logic [EXP_W-1:0] EXP_FINE [16] = '{
      17'd65536, 17'd65280, 17'd65026, 17'd64772, 17'd64520, 17'd64268, 17'd64018, 17'd63768,
      17'd63520, 17'd63272, 17'd63025, 17'd62780, 17'd62535, 17'd62291, 17'd62048, 17'd61806};

endpackage

@@ sv/gkr_if.sv @@
interface gkr_req_if import gkr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [SIDX_W-1:0]        sample_index;
   logic [DIDX_W-1:0]        dim_index;
   logic signed [VAL_W-1:0]  value;

   modport source(output valid, mode, sample_index, dim_index, value, input ready);
   modport sink(input valid, mode, sample_index, dim_index, value, output ready);
endinterface

interface gkr_rsp_if import gkr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  estimate;
   logic                     no_samples;

   modport source(output valid, estimate, no_samples, input ready);
   modport sink(input valid, estimate, no_samples, output ready);
endinterface

@@ sv/gkr_div.sv @@
module gkr_div import gkr_pkg::*; #(
   parameter int NUM_W = 52,
   parameter int DEN_W = 28
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic             ge;
   logic [DEN_W:0]   rem_in;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, divisor};
      rem_in = ge ? rem_sh - {1'b0, divisor} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            cnt_ff  <= CNT_W'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ sv/gaussian_kernel_regression_top.sv @@
// Channel | Dir | Payload                                   | Handshake
// req_ch  | in  | mode, sample_index, dim_index, value      | valid/ready
// rsp_ch  | out | estimate, no_samples                      | valid/ready
// csr_*   | in  | csr_index, csr_wdata                      | csr_we
//
// Every product goes through one shared 26x26 multiplier and the final division
// is one quotient bit a cycle; a sample whose weight is cut off skips the
// exponential steps. An empty table is answered straight from idle. Reset is
// synchronous; the stores are not cleared. req_ch.ready is low while an evaluate
// item is in work or a result waits for the output register; a result waiting in
// the output register holds there while load items are still taken.
`include "gaussian_kernel_regression_top_assert.svh"
module gaussian_kernel_regression_top import gkr_pkg::*; #(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int MAX_DIMS    = DEF_MAX_DIMS
)(
   input  logic                  clock,
   input  logic                  reset,
   gkr_req_if.sink               req_ch,
   gkr_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int SI_W       = $clog2(MAX_SAMPLES);
   localparam int DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
   localparam int DCNT_W     = $clog2(MAX_DIMS + 1);
   localparam int FEAT_DEPTH = MAX_SAMPLES << DIM_W;
   localparam int D2_W       = 48 + $clog2(MAX_DIMS);
   localparam int NUM_W      = 41 + CNT_W;
   localparam int DEN_W      = EXP_W + CNT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_P1_RD, S_P1_MUL, S_P1_ACC, S_P1_SCH, S_P1_SCL, S_P1_SUM,
      S_P2_RD, S_P2_E1, S_P2_E2, S_P2_E3, S_P2_E4, S_P2_WT, S_P2_ACC,
      S_DIVGO, S_DIVW
   } state_type;

   // configuration
   logic [SCNT_W-1:0]  sample_count_ff;
   logic [DUSED_W-1:0] dims_used_ff;
   logic [INVW_W-1:0]  inv_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= RST_SAMPLE_COUNT;
         dims_used_ff    <= RST_DIMS_USED;
         inv_width_ff    <= RST_INV_WIDTH;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[SCNT_W-1:0];
            CSR_DIMS_USED:    dims_used_ff    <= csr_wdata[DUSED_W-1:0];
            CSR_INV_WIDTH:    inv_width_ff    <= csr_wdata[INVW_W-1:0];
            default: ;
         endcase
      end
   end

   state_type               state_ff;
   logic [CNT_W-1:0]        i_ff, n_ff;
   logic [DCNT_W-1:0]       j_ff, d_ff;
   logic [D2_W-1:0]         d2_ff;
   logic [PH_W-1:0]         ph_ff;
   logic [SD_W-1:0]         min_ff;
   logic [3:0]              m_ff;
   logic [EXP_W-1:0]        t_ff, w_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0]        den_ff;
   logic                    rsp_valid_ff, rsp_nos_ff, pend_nos_ff;
   logic signed [VAL_W-1:0] rsp_est_ff, pend_est_ff;
   logic                    out_pend_ff;

   logic req_fire;
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) & ~out_pend_ff;

   // stores
   logic si_ok, di_ok;
   assign si_ok = 32'(req_ch.sample_index) < MAX_SAMPLES;
   assign di_ok = 32'(req_ch.dim_index) < MAX_DIMS;

   logic signed [VAL_W-1:0] feat_mem [FEAT_DEPTH];
   logic signed [VAL_W-1:0] tgt_mem [MAX_SAMPLES];
   logic [SD_W-1:0]         sd_mem [MAX_SAMPLES];
   logic signed [VAL_W-1:0] query_ff [MAX_DIMS];
   logic signed [VAL_W-1:0] feat_q_ff, tgt_q_ff;
   logic [SD_W-1:0]         sd_q_ff;
   logic [SI_W-1:0]         wr_si, rd_si;
   logic [DIM_W-1:0]        wr_di, rd_di;
   logic                    sd_we;
   logic [SD_W-1:0]         sd_val;

   assign wr_si = SI_W'(req_ch.sample_index);
   assign wr_di = DIM_W'(req_ch.dim_index);
   assign rd_si = i_ff[SI_W-1:0];
   assign rd_di = j_ff[DIM_W-1:0];

   always_ff @(posedge clock) begin
      if (req_fire && req_ch.mode == MODE_FEATURE && si_ok && di_ok)
         feat_mem[{wr_si, wr_di}] <= req_ch.value;
      feat_q_ff <= feat_mem[{rd_si, rd_di}];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_ch.mode == MODE_TARGET && si_ok)
         tgt_mem[wr_si] <= req_ch.value;
      tgt_q_ff <= tgt_mem[rd_si];
   end

   always_ff @(posedge clock) begin
      if (sd_we)
         sd_mem[rd_si] <= sd_val;
      sd_q_ff <= sd_mem[rd_si];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_ch.mode == MODE_QUERY && di_ok)
         query_ff[wr_di] <= req_ch.value;
   end

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p_ff;

   logic signed [VAL_W:0] diff_s, ad_s;
   logic [VAL_W-1:0]      ad;
   logic [A_W-1:0]        a_val;
   logic [SD_W-1:0]       delta;
   logic [PSUM_W-1:0]     psum;

   always_comb begin
      diff_s = (VAL_W+1)'(feat_q_ff) - (VAL_W+1)'(query_ff[rd_di]);
      ad_s   = diff_s[VAL_W] ? -diff_s : diff_s;
      ad     = ad_s[VAL_W-1:0];
      a_val  = A_W'(d2_ff[D2_W-1:8]);
      delta  = sd_q_ff - min_ff;
      psum   = (PSUM_W'(ph_ff) << HALF_W) + PSUM_W'(mul_p_ff[PH_W-1:0]);
      sd_val = (|psum[PSUM_W-1:PSAT_B]) ? {SD_W{1'b1}} : psum[PSAT_B-1:8];
      sd_we  = (state_ff == S_P1_SUM);
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_P1_MUL: begin
            mul_a = MUL_W'(ad);
            mul_b = MUL_W'(ad);
         end
         S_P1_SCH: begin
            mul_a = MUL_W'(a_val[A_W-1:HALF_W]);
            mul_b = MUL_W'(inv_width_ff);
         end
         S_P1_SCL: begin
            mul_a = MUL_W'(a_val[HALF_W-1:0]);
            mul_b = MUL_W'(inv_width_ff);
         end
         S_P2_E1: begin
            mul_a = MUL_W'(EXP_INT[delta[17:16]]);
            mul_b = MUL_W'(EXP_SIXTEENTH[delta[15:12]]);
         end
         S_P2_E3: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(EXP_FINE[m_ff]);
         end
         S_P2_WT: begin
            mul_a = MUL_W'(w_ff);
            mul_b = MUL_W'(tgt_q_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   // divider
   logic             div_done;
   logic [NUM_W-1:0] div_q, mag, dvd;
   logic [VAL_W-1:0] q_lo;

   assign mag  = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign dvd  = mag + NUM_W'(den_ff >> 1);
   assign q_lo = div_q[VAL_W-1:0];

   gkr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIVGO),
      .dividend (dvd),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   logic [CNT_W-1:0]  n_in;
   logic [DCNT_W-1:0] d_in;
   assign n_in = (32'(sample_count_ff) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES)
                                                       : CNT_W'(sample_count_ff);
   assign d_in = (32'(dims_used_ff) > MAX_DIMS) ? DCNT_W'(MAX_DIMS)
                                                 : DCNT_W'(dims_used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         out_pend_ff  <= 1'b0;
      end else begin
         // result waits here until the output register is free
         if (out_pend_ff && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_est_ff   <= pend_est_ff;
            rsp_nos_ff   <= pend_nos_ff;
            out_pend_ff  <= 1'b0;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire && req_ch.mode == MODE_EVAL) begin
                  n_ff  <= n_in;
                  d_ff  <= d_in;
                  i_ff  <= '0;
                  j_ff  <= '0;
                  d2_ff <= '0;
                  num_ff <= '0;
                  den_ff <= '0;
                  if (n_in == '0) begin
                     pend_est_ff <= '0;
                     pend_nos_ff <= 1'b1;
                     out_pend_ff <= 1'b1;
                  end else begin
                     state_ff <= (d_in == '0) ? S_P1_SCH : S_P1_RD;
                  end
               end
            end
            S_P1_RD:  state_ff <= S_P1_MUL;
            S_P1_MUL: state_ff <= S_P1_ACC;
            S_P1_ACC: begin
               d2_ff <= d2_ff + D2_W'(mul_p_ff[2*VAL_W-1:0]);
               j_ff  <= j_ff + 1'b1;
               state_ff <= (j_ff + 1'b1 == d_ff) ? S_P1_SCH : S_P1_RD;
            end
            S_P1_SCH: state_ff <= S_P1_SCL;
            S_P1_SCL: begin
               ph_ff    <= mul_p_ff[PH_W-1:0];
               state_ff <= S_P1_SUM;
            end
            S_P1_SUM: begin
               if (i_ff == '0 || sd_val < min_ff)
                  min_ff <= sd_val;
               d2_ff <= '0;
               j_ff  <= '0;
               if (i_ff + 1'b1 == n_ff) begin
                  i_ff     <= '0;
                  state_ff <= S_P2_RD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= (d_ff == '0) ? S_P1_SCH : S_P1_RD;
               end
            end
            S_P2_RD: state_ff <= S_P2_E1;
            S_P2_E1: begin
               m_ff <= delta[11:8];
               if (delta > LOG_CUTOFF) begin
                  w_ff     <= '0;
                  state_ff <= S_P2_WT;
               end else begin
                  state_ff <= S_P2_E2;
               end
            end
            S_P2_E2: begin
               t_ff     <= EXP_W'((mul_p_ff + PROD_W'(32768)) >>> 16);
               state_ff <= S_P2_E3;
            end
            S_P2_E3: state_ff <= S_P2_E4;
            S_P2_E4: begin
               w_ff     <= EXP_W'((mul_p_ff + PROD_W'(32768)) >>> 16);
               state_ff <= S_P2_WT;
            end
            S_P2_WT: state_ff <= S_P2_ACC;
            S_P2_ACC: begin
               num_ff <= num_ff + NUM_W'(mul_p_ff);
               den_ff <= den_ff + DEN_W'(w_ff);
               if (i_ff + 1'b1 == n_ff) begin
                  state_ff <= S_DIVGO;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_P2_RD;
               end
            end
            S_DIVGO: state_ff <= S_DIVW;
            S_DIVW: begin
               if (div_done) begin
                  pend_est_ff <= num_ff[NUM_W-1] ? -q_lo : q_lo;
                  pend_nos_ff <= 1'b0;
                  out_pend_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.estimate   = rsp_est_ff;
   assign rsp_ch.no_samples = rsp_nos_ff;

   `GKR_ASSERT(a_eval_blocks, clock, reset,
      (req_fire && req_ch.mode == MODE_EVAL) |=> !req_ch.ready,
      "evaluate transfer did not block input")
   `GKR_ASSERT(a_empty_zero, clock, reset,
      (rsp_ch.valid && rsp_ch.no_samples) |-> (rsp_ch.estimate == '0),
      "empty table gave nonzero estimate")
   `GKR_ASSERT(a_den_nonzero, clock, reset,
      (state_ff == S_DIVGO) |-> (den_ff != '0),
      "weight sum is zero at divide")
   `GKR_NEVER(a_index_bound, clock, reset,
      (state_ff == S_P1_RD || state_ff == S_P2_RD) && (i_ff >= n_ff),
      "sample index past count")
endmodule

@@ tb/gaussian_kernel_regression_top_test.sv @@
`timescale 1ns / 1ps

module gaussian_kernel_regression_top_test;
   import gkr_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int ITEM_GOAL  = 1350;
   localparam int STALL_MAX  = 200000;
   localparam int DRAIN_WAIT = 40;
   localparam int HOLD_LEN   = 20000;
   localparam longint unsigned PROD_SAT = 64'hFF_FFFF_FFFF_FFFF;

   class kernel_scoreboard;
      int                    feature_mem [DEF_MAX_SAMPLES][DEF_MAX_DIMS];
      int                    target_mem  [DEF_MAX_SAMPLES];
      int                    query_mem   [DEF_MAX_DIMS];
      logic [SCNT_W-1:0]     n_samples;
      logic [DUSED_W-1:0]    n_dims;
      logic [INVW_W-1:0]     inv_width;
      logic [VAL_W:0]        estimate_q[$];   // {no_samples, estimate}
      int                    errors;

      function new();
         n_samples = RST_SAMPLE_COUNT;
         n_dims    = RST_DIMS_USED;
         inv_width = RST_INV_WIDTH;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SAMPLE_COUNT: n_samples = data[SCNT_W-1:0];
            CSR_DIMS_USED:    n_dims    = data[DUSED_W-1:0];
            CSR_INV_WIDTH:    inv_width = data[INVW_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned kernel_weight(longint unsigned delta);
         longint unsigned t;
         if (delta > LOG_CUTOFF) return 0;
         t = (longint'(EXP_INT[delta[17:16]]) * longint'(EXP_SIXTEENTH[delta[15:12]])
              + 32768) >> 16;
         return (t * longint'(EXP_FINE[delta[11:8]]) + 32768) >> 16;
      endfunction

      function logic [VAL_W-1:0] weighted_mean(int n, int d);
         longint unsigned sdist [DEF_MAX_SAMPLES];
         longint unsigned d2, a, min_dist, w, den, mag, q;
         longint          diff, num;
         for (int i = 0; i < n; i++) begin
            d2 = 0;
            for (int j = 0; j < d; j++) begin
               diff = longint'(feature_mem[i][j]) - longint'(query_mem[j]);
               if (diff < 0) diff = -diff;
               d2 += longint'(diff) * longint'(diff);
            end
            a = d2 >> 8;
            if (inv_width != 0 && a > PROD_SAT / inv_width) sdist[i] = PROD_SAT >> 8;
            else sdist[i] = (a * inv_width) >> 8;
            if (i == 0 || sdist[i] < min_dist) min_dist = sdist[i];
         end
         num = 0;
         den = 0;
         for (int i = 0; i < n; i++) begin
            w = kernel_weight(sdist[i] - min_dist);
            num += longint'(w) * longint'(target_mem[i]);
            den += w;
         end
         mag = (num < 0) ? longint'(-num) : longint'(num);
         q = (mag + den / 2) / den;
         if (num < 0) q = -q;
         return q[VAL_W-1:0];
      endfunction

      function void note_transfer(logic [MODE_W-1:0] m, logic [SIDX_W-1:0] si,
                                  logic [DIDX_W-1:0] di, logic signed [VAL_W-1:0] v);
         int n, d;
         case (m)
            MODE_FEATURE: feature_mem[si][di] = v;
            MODE_TARGET:  target_mem[si] = v;
            MODE_QUERY:   query_mem[di] = v;
            default: begin
               n = (n_samples > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : n_samples;
               d = (n_dims > DEF_MAX_DIMS) ? DEF_MAX_DIMS : n_dims;
               if (n == 0) estimate_q.push_back({1'b1, {VAL_W{1'b0}}});
               else estimate_q.push_back({1'b0, weighted_mean(n, d)});
            end
         endcase
      endfunction

      function void check_result(logic [VAL_W-1:0] est, logic empty);
         logic [VAL_W:0] exp_r;
         if (estimate_q.size() == 0) begin
            $display("%0t: unexpected result estimate=%h no_samples=%b", $time, est, empty);
            errors++;
            return;
         end
         exp_r = estimate_q.pop_front();
         if (est !== exp_r[VAL_W-1:0]) begin
            $display("%0t: estimate mismatch expected %h actual %h",
                     $time, exp_r[VAL_W-1:0], est);
            errors++;
         end
         if (empty !== exp_r[VAL_W]) begin
            $display("%0t: no_samples mismatch expected %b actual %b",
                     $time, exp_r[VAL_W], empty);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gkr_req_if req_ch();
   gkr_rsp_if rsp_ch();

   gaussian_kernel_regression_top u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   kernel_scoreboard sb = new();

   int  req_idle = 17;
   int  rsp_idle = 49;
   int  items_sent = 0;
   int  stall_cycles = 0;
   int  hold_left = 0;
   bit  pressure_req = 0;
   bit  pressure_done = 0;
   bit  feat_ok  [DEF_MAX_SAMPLES][DEF_MAX_DIMS];
   bit  targ_ok  [DEF_MAX_SAMPLES];
   bit  query_ok [DEF_MAX_DIMS];

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_FEATURE;
      req_ch.sample_index = '0;
      req_ch.dim_index = '0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls plus one long hold-off to back the block up
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.estimate, rsp_ch.no_samples);
      if (pressure_req && !pressure_done) begin
         pressure_done = 1;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] m, input logic [SIDX_W-1:0] si,
                            input logic [DIDX_W-1:0] di, input logic [VAL_W-1:0] v);
      while ($urandom_range(99) < req_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= m;
      req_ch.sample_index <= si;
      req_ch.dim_index <= di;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_transfer(m, si, di, v);
      items_sent++;
      if (items_sent < ITEM_GOAL / 3) begin
         req_idle = 17; rsp_idle = 49;
      end else if (items_sent < 2 * ITEM_GOAL / 3) begin
         req_idle = 49; rsp_idle = 17;
      end else begin
         req_idle = 0; rsp_idle = 0;
      end
   endtask

   task automatic load(input logic [MODE_W-1:0] m, input int si, input int di,
                       input logic [VAL_W-1:0] v);
      send_item(m, si[SIDX_W-1:0], di[DIDX_W-1:0], v);
      case (m)
         MODE_FEATURE: feat_ok[si][di] = 1;
         MODE_TARGET:  targ_ok[si] = 1;
         default:      query_ok[di] = 1;
      endcase
   endtask

   task automatic evaluate();
      send_item(MODE_EVAL, SIDX_W'($urandom), DIDX_W'($urandom), VAL_W'($urandom));
   endtask

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
         1, 2: return VAL_W'($urandom);
         default: return 24'($signed($urandom_range(16384)) - 8192);
      endcase
   endfunction

   // fill whatever an evaluate will read that has never been written
   task automatic fill_unwritten();
      int n, d;
      n = (sb.n_samples > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : sb.n_samples;
      d = (sb.n_dims > DEF_MAX_DIMS) ? DEF_MAX_DIMS : sb.n_dims;
      if (n == 0) return;
      for (int j = 0; j < d; j++)
         if (!query_ok[j]) load(MODE_QUERY, $urandom_range(1023), j, rand_value());
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < d; j++)
            if (!feat_ok[i][j]) load(MODE_FEATURE, i, j, rand_value());
         if (!targ_ok[i]) load(MODE_TARGET, i, $urandom_range(7), rand_value());
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.estimate_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic configure(input int n, input int d, input logic [INVW_W-1:0] inv);
      csr_write(CSR_SAMPLE_COUNT, CSR_DATA_W'(n));
      csr_write(CSR_DIMS_USED, CSR_DATA_W'(d));
      csr_write(CSR_INV_WIDTH, inv);
   endtask

   initial begin
      int n, d, si;
      logic [INVW_W-1:0] inv;
      logic [MODE_W-1:0] m;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table straight out of reset
      evaluate();
      load(MODE_QUERY, 0, 0, 24'h800000);
      load(MODE_QUERY, 0, 1, 24'h7FFFFF);
      load(MODE_FEATURE, 0, 0, 24'h7FFFFF);
      load(MODE_FEATURE, 1, 1, 24'h800000);
      load(MODE_TARGET, 0, 0, 24'h7FFFFF);
      load(MODE_TARGET, 1, 0, 24'h800000);
      load(MODE_TARGET, 2, 0, 24'h000000);
      configure(3, 15, 24'hFFFFFF);
      fill_unwritten();
      evaluate();
      csr_write(CSR_INV_WIDTH, '0);
      evaluate();
      csr_write(CSR_DIMS_USED, '0);
      evaluate();
      csr_write(CSR_UNUSED, CSR_DATA_W'($urandom));
      evaluate();
      csr_write(CSR_SAMPLE_COUNT, '0);
      evaluate();

      while (items_sent < ITEM_GOAL - DEF_MAX_SAMPLES || !pressure_req) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(0, 48) : $urandom_range(1, 10);
         d = $urandom_range(15);
         case ($urandom_range(4))
            0: inv = '0;
            1: inv = 24'hFFFFFF;
            2: inv = INVW_W'($urandom);
            3: inv = RST_INV_WIDTH;
            default: inv = INVW_W'($urandom_range(4096));
         endcase
         configure(n, d, inv);
         if ($urandom_range(3) == 0) csr_write(CSR_UNUSED, CSR_DATA_W'($urandom));
         if (items_sent > 100 && !pressure_req) pressure_req = 1;
         // enough evaluates during the hold-off to fill the block
         repeat ((pressure_req && !pressure_done) ? 4 : $urandom_range(2, 6)) begin
            repeat ($urandom_range(0, 2 * n + 2)) begin
               m = MODE_W'($urandom_range(2));
               si = ($urandom_range(7) == 0 || n == 0) ? $urandom_range(1023)
                                                      : $urandom_range(n - 1);
               load(m, si, $urandom_range(7), rand_value());
            end
            fill_unwritten();
            evaluate();
         end
      end

      // full table, no dimensions, count above the store size
      configure(2047, 0, 24'd256);
      for (int i = 0; i < DEF_MAX_SAMPLES; i++)
         load(MODE_TARGET, i, 0, rand_value());
      fill_unwritten();
      evaluate();
      csr_write(CSR_SAMPLE_COUNT, CSR_DATA_W'(DEF_MAX_SAMPLES));
      evaluate();

      req_ch.valid <= 1'b0;
      while (sb.estimate_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/gkr_pkg.sv
sv/gkr_if.sv
sv/gkr_div.sv
sv/gaussian_kernel_regression_top.sv
tb/gaussian_kernel_regression_top_test.sv
